[hdl/expression_token_scanner_assert.svh]
// Assertion macros shared by the expression token scanner.
`ifndef EXPRESSION_TOKEN_SCANNER_ASSERT_SVH
`define EXPRESSION_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ETS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ETS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

[hdl/ets_pkg.sv]
// Package with the types, constants and helpers of the expression token scanner.
package ets_pkg;

   localparam int POS_WIDTH   = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int SAT_WIDTH   = (POS_WIDTH > FIELD_WIDTH) ? POS_WIDTH : FIELD_WIDTH;
   localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = '1;

   localparam int FIFO_DEPTH  = 8;
   localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int LEVEL_WIDTH = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] DOT_CHAR        = 8'h2E;
   localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;
   localparam logic [7:0] PERCENT_CHAR    = 8'h25;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_IDENT  = 2'd1,
      MODE_NUMBER = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      KIND_ILLEGAL = 4'd0,
      KIND_EOF     = 4'd1,
      KIND_IDENT   = 4'd2,
      KIND_INT     = 4'd3,
      KIND_FLOAT   = 4'd4,
      KIND_RPAREN  = 4'd5,
      KIND_LPAREN  = 4'd6,
      KIND_PLUS    = 4'd7,
      KIND_MINUS   = 4'd8,
      KIND_MUL     = 4'd9,
      KIND_DIV     = 4'd10,
      KIND_MOD     = 4'd11
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [FIELD_WIDTH-1:0] start;
      logic [FIELD_WIDTH-1:0] length;
      logic                   last;
   } result_type;

   // Results caused by one item; a lone result is always in first.
   typedef struct packed {
      result_type first;
      result_type second;
      logic [1:0] num;
   } scan_out_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] level;
      logic                   not_empty;
   } fifo_status_type;

   function automatic logic [FIELD_WIDTH-1:0] sat_field(input logic [POS_WIDTH-1:0] pos);
      logic [SAT_WIDTH-1:0] wide;
      wide = SAT_WIDTH'(pos);
      if (wide > SAT_WIDTH'(FIELD_MAX)) begin
         return FIELD_MAX;
      end
      return wide[FIELD_WIDTH-1:0];
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      case (c)
         8'h2B:        return KIND_PLUS;
         8'h2D:        return KIND_MINUS;
         8'h2A:        return KIND_MUL;
         8'h2F:        return KIND_DIV;
         PERCENT_CHAR: return KIND_MOD;
         8'h28:        return KIND_LPAREN;
         8'h29:        return KIND_RPAREN;
         default:      return KIND_ILLEGAL;
      endcase
   endfunction

endpackage

[hdl/ets_scan_core.sv]
// Scanner state and per-item token classification.
module ets_scan_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic                 item_op,
   input  logic [7:0]           item_char,
   output ets_pkg::scan_out_type scan_out
);
   import ets_pkg::*;

   mode_type               mode_ff, mode_in;
   logic                   dot_ff, dot_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   start_ff, start_in;
   logic [FIELD_WIDTH-1:0] len_ff, len_in;

   mode_type               mode_eff;
   logic                   is_alpha, is_digit, is_sep, is_word, pending, is_tok;
   logic [POS_WIDTH-1:0]   pos_adv;
   logic [FIELD_WIDTH-1:0] len_grow;
   result_type             pend_res, tok_res, eof_res;

   always_comb begin
      case (mode_ff)
         MODE_IDENT:  mode_eff = MODE_IDENT;
         MODE_NUMBER: mode_eff = MODE_NUMBER;
         default:     mode_eff = MODE_IDLE;
      endcase

      is_alpha = item_char inside {[8'h61:8'h7A], [8'h41:8'h5A], UNDERSCORE_CHAR};
      is_digit = item_char inside {[8'h30:8'h39]};
      is_sep   = item_char inside {8'h20, 8'h0D, 8'h0A};
      is_word  = is_alpha || is_digit;
      is_tok   = !is_sep && !is_word;
      pending  = (mode_eff != MODE_IDLE);

      pos_adv  = (pos_ff == '1) ? pos_ff : pos_ff + POS_WIDTH'(1);
      len_grow = (len_ff == FIELD_MAX) ? len_ff : len_ff + FIELD_WIDTH'(1);

      pend_res.kind   = (mode_eff == MODE_IDENT) ? KIND_IDENT :
                        (dot_ff ? KIND_FLOAT : KIND_INT);
      pend_res.start  = sat_field(start_ff);
      pend_res.length = len_ff;
      pend_res.last   = 1'b0;

      tok_res.kind    = single_kind(item_char);
      tok_res.start   = sat_field(pos_ff);
      tok_res.length  = FIELD_WIDTH'(1);
      tok_res.last    = 1'b1;

      eof_res.kind    = KIND_EOF;
      eof_res.start   = sat_field(pos_ff);
      eof_res.length  = '0;
      eof_res.last    = 1'b1;

      mode_in  = mode_ff;
      dot_in   = dot_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      len_in   = len_ff;

      scan_out.first  = pend_res;
      scan_out.second = tok_res;
      scan_out.num    = 2'd0;

      if (item_valid) begin
         if (item_op == OP_END) begin
            mode_in  = MODE_IDLE;
            dot_in   = 1'b0;
            pos_in   = '0;
            start_in = '0;
            len_in   = '0;
            if (pending) begin
               scan_out.second = eof_res;
               scan_out.num    = 2'd2;
            end else begin
               scan_out.first  = eof_res;
               scan_out.num    = 2'd1;
            end
         end else if (mode_eff == MODE_IDENT && is_word) begin
            len_in = len_grow;
            pos_in = pos_adv;
         end else if (mode_eff == MODE_NUMBER && (is_digit || item_char == DOT_CHAR)) begin
            dot_in = dot_ff || (item_char == DOT_CHAR);
            len_in = len_grow;
            pos_in = pos_adv;
         end else begin
            // A byte that cannot extend the pending token flushes it first.
            mode_in = MODE_IDLE;
            dot_in  = 1'b0;
            pos_in  = pos_adv;
            if (is_word) begin
               mode_in  = is_digit ? MODE_NUMBER : MODE_IDENT;
               start_in = pos_ff;
               len_in   = FIELD_WIDTH'(1);
            end
            scan_out.num = {1'b0, pending} + {1'b0, is_tok};
            if (!pending) begin
               scan_out.first = tok_res;
            end else if (!is_tok) begin
               scan_out.first.last = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         dot_ff   <= 1'b0;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         dot_ff   <= dot_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

endmodule

[hdl/ets_result_fifo.sv]
// Result queue that takes up to two results a cycle and delivers one per pop.
module ets_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  ets_pkg::scan_out_type    push,
   input  logic                     pop,
   output ets_pkg::result_type      head,
   output ets_pkg::fifo_status_type status
);
   import ets_pkg::*;

   result_type             mem_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                   do_pop;

   always_comb begin
      do_pop    = pop && (level_ff != '0);
      wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(do_pop);
      level_in  = level_ff + LEVEL_WIDTH'(push.num) - LEVEL_WIDTH'(do_pop);

      head             = mem_ff[rd_ptr_ff];
      status.level     = level_ff;
      status.not_empty = (level_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_WIDTH'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

[hdl/expression_token_scanner.sv]
// Expression token scanner: one byte or end mark in, tokens out.
//
// The req channel carries one item per handshake: req_operation selects a
// character byte (0) or end of input (1), req_char_byte holds the byte. The
// rsp channel carries tokens: kind, start position, length and a flag on the
// last token that an item caused. An item is taken at a clock edge with valid
// high and stall low on its channel.
// An accepted item lands in an input register, is classified in the next
// cycle and its tokens enter an eight-entry result queue, from whose head
// the first token can be taken once it has been written there.
// One item is accepted every cycle while req_stall is low; an item that
// yields two tokens needs an extra rsp handshake, absorbed by the queue.
// req_stall rises when the queue could not hold the tokens of the item in the
// input register and of one more.
// Synchronous reset empties the queue and returns the scanner to idle at
// position zero. A stalled rsp side holds the current token steady and keeps
// queuing until the queue is full enough to stall req.
`include "expression_token_scanner_assert.svh"
module expression_token_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_char_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_start_position,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import ets_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic                   in_op_ff;
   logic [7:0]             in_char_ff;
   logic                   req_accept;
   logic [LEVEL_WIDTH+1:0] reserve;
   scan_out_type           scan_out;
   result_type             head;
   fifo_status_type        status;

   always_comb begin
      // Room is kept for the item in the input register and one more.
      reserve     = (LEVEL_WIDTH+2)'(status.level) + (LEVEL_WIDTH+2)'(in_valid_ff ? 4 : 2);
      req_stall   = reserve > (LEVEL_WIDTH+2)'(FIFO_DEPTH);
      req_accept  = req_valid && !req_stall;
      in_valid_in = req_accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= req_operation;
         in_char_ff <= req_char_byte;
      end
   end

   ets_scan_core u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item_op    (in_op_ff),
      .item_char  (in_char_ff),
      .scan_out   (scan_out)
   );

   ets_result_fifo u_result_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (scan_out),
      .pop    (rsp_valid && !rsp_stall),
      .head   (head),
      .status (status)
   );

   assign rsp_valid          = status.not_empty;
   assign rsp_token_kind     = head.kind;
   assign rsp_start_position = head.start;
   assign rsp_token_length   = head.length;
   assign rsp_last_of_run    = head.last;

   `ETS_ASSERT_IMPLY(a_level_bound, clock, reset, 1'b1, status.level <= LEVEL_WIDTH'(FIFO_DEPTH))
   `ETS_ASSERT_IMPLY(a_pair_queued, clock, reset, rsp_valid && !rsp_last_of_run, status.level >= LEVEL_WIDTH'(2))
   `ETS_ASSERT_IMPLY(a_eof_shape, clock, reset, rsp_valid && rsp_token_kind == KIND_EOF, rsp_token_length == 16'd0 && rsp_last_of_run)
   `ETS_ASSERT_NEXT(a_push_lands, clock, reset, !reset && in_valid_ff && scan_out.num != 2'd0 && !(rsp_valid && !rsp_stall), status.not_empty)

endmodule
